// ===== rtl/cidat_pkg.sv =====
`default_nettype none

package cidat_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } state_t;

    localparam int ID_W   = 32;
    localparam int HITS_W = 8;
    localparam int SLOT_W = 6;
    localparam int OCC_W  = 7;
    localparam int OUT_W  = 32;

    // One table slot as it travels around the ring
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              valid;
        logic [HITS_W-1:0] hits;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctl_t;

    typedef struct packed {
        logic              success;
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  occupied;
        logic [HITS_W-1:0] hits;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/card_id_allow_table_core.sv =====
`default_nettype none
// Card ID allow table: TABLE_DEPTH slots of {32-bit ID, valid, 8-bit hit count}.
// Input channel s_*: s_tuser[1:0] carries the opcode (insert, delete, search,
// clear), s_tdata the card ID. One item is taken at a time; s_tready is high
// only while the block is idle.
// Result channel m_*: one item per request with success, status, slot,
// occupied count and hit count, held in an output register until taken.
// The slots sit in a ring of cells that rotates one position per cycle while a scan
// or write is under way; the controller inspects and rewrites the slot passing its head.
// A full rotation returns every slot to its home cell.
// Delete and search take one rotation of the ring, a successful insert one rotation
// to scan and one to write, a failed insert one rotation; clear and early rejects
// (full, empty) go straight to the result.
// The next item can be taken in the cycle after the result is loaded.
// Reset empties all slots and the count at once; clear does the same as it is accepted.
// A stalled m_tready holds the result; a finished item then waits in the
// controller and the next item is not taken until the result moves out.
module card_id_allow_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // card_id[31:0]
    input  wire logic [7:0]  s_tuser,   // opcode[1:0], zeros above
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // success[0], status[3:1], slot[9:4],
                                        // occupied[16:10], hits[24:17], zeros above
);

    cidat_pkg::entry_t    ring_q [TABLE_DEPTH];
    cidat_pkg::entry_t    wb;
    cidat_pkg::ring_ctl_t ctl;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
        if (i == TABLE_DEPTH - 1) begin : g_tail
            cidat_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .din     (wb),
                .dout    (ring_q[i])
            );
        end else begin : g_body
            cidat_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .din     (ring_q[i+1]),
                .dout    (ring_q[i])
            );
        end
    end

    cidat_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .head     (ring_q[0]),
        .wb       (wb),
        .ctl      (ctl)
    );

endmodule

`default_nettype wire

// ===== rtl/cidat_cell.sv =====
`default_nettype none

module cidat_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cidat_pkg::ring_ctl_t ctl,
    input  wire cidat_pkg::entry_t  din,
    output cidat_pkg::entry_t       dout
);

    cidat_pkg::entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            entry_reg <= '0;
        end else if (ctl.shift) begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/cidat_ctrl.sv =====
`default_nettype none

module cidat_ctrl #(
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tuser,
    input  wire logic [cidat_pkg::ID_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [cidat_pkg::OUT_W-1:0]   m_tdata,
    input  wire cidat_pkg::entry_t        head,
    output cidat_pkg::entry_t             wb,
    output cidat_pkg::ring_ctl_t          ctl
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RES_W = 1 + 3 + cidat_pkg::SLOT_W + cidat_pkg::OCC_W + cidat_pkg::HITS_W;

    cidat_pkg::state_t  state_reg, state_next;
    cidat_pkg::opcode_t op_reg, op_next;
    logic [cidat_pkg::ID_W-1:0]   id_reg, id_next;
    logic [IDX_W-1:0]             pos_reg, pos_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         found_reg, found_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    logic                         free_reg, free_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;
    logic                         cnt_free_reg, cnt_free_next;
    logic [cidat_pkg::HITS_W-1:0] hits_reg, hits_next;
    cidat_pkg::result_t           res_reg, res_next;
    logic                         m_valid_reg, m_valid_next;
    logic [cidat_pkg::OUT_W-1:0]  m_data_reg, m_data_next;

    logic                         accept;
    cidat_pkg::opcode_t           in_op;
    logic                         last;
    logic                         match;
    logic                         first_hit;
    logic                         pos_is_count;
    logic                         free_now;
    logic                         cnt_free_now;
    logic [IDX_W-1:0]             first_free;
    logic [IDX_W-1:0]             target;
    logic [IDX_W-1:0]             hit_idx;
    logic [cidat_pkg::HITS_W-1:0] head_hits_inc;
    logic                         out_free;

    function automatic cidat_pkg::result_t mk_result(
        input logic                         ok,
        input cidat_pkg::status_t           st,
        input logic [IDX_W-1:0]             idx,
        input logic [CNT_W-1:0]             cnt,
        input logic [cidat_pkg::HITS_W-1:0] h
    );
        cidat_pkg::result_t r;
        logic [IDX_W+cidat_pkg::SLOT_W-1:0] idx_ext;
        logic [CNT_W+cidat_pkg::OCC_W-1:0]  cnt_ext;
        idx_ext    = {{cidat_pkg::SLOT_W{1'b0}}, idx};
        cnt_ext    = {{cidat_pkg::OCC_W{1'b0}}, cnt};
        r.success  = ok;
        r.status   = st;
        r.slot     = idx_ext[cidat_pkg::SLOT_W-1:0];
        r.occupied = cnt_ext[cidat_pkg::OCC_W-1:0];
        r.hits     = h;
        return r;
    endfunction

    assign in_op         = cidat_pkg::opcode_t'(s_tuser[1:0]);
    assign accept        = s_tvalid && s_tready;
    assign last          = (pos_reg == IDX_W'(DEPTH - 1));
    assign match         = head.valid && (head.id == id_reg);
    assign first_hit     = match && !found_reg;
    assign pos_is_count  = (CNT_W'(pos_reg) == count_reg);
    assign free_now      = free_reg || !head.valid;
    assign cnt_free_now  = cnt_free_reg || (pos_is_count && !head.valid);
    assign first_free    = free_reg ? free_idx_reg : pos_reg;
    assign target        = cnt_free_now ? count_reg[IDX_W-1:0] : first_free;
    assign hit_idx       = found_reg ? slot_reg : pos_reg;
    assign head_hits_inc = head.hits + cidat_pkg::HITS_W'(1);
    assign out_free      = !m_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cidat_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = cidat_pkg::S_RESULT;
                    if ((in_op == cidat_pkg::OP_INSERT) && (count_reg < CNT_W'(DEPTH))) begin
                        state_next = cidat_pkg::S_SCAN;
                    end
                    if (((in_op == cidat_pkg::OP_DELETE) || (in_op == cidat_pkg::OP_SEARCH))
                        && (count_reg != '0)) begin
                        state_next = cidat_pkg::S_SCAN;
                    end
                end
            end
            cidat_pkg::S_SCAN: begin
                if (last) begin
                    if ((op_reg == cidat_pkg::OP_INSERT) && !(found_reg || match) && free_now) begin
                        state_next = cidat_pkg::S_WRITE;
                    end else begin
                        state_next = cidat_pkg::S_RESULT;
                    end
                end
            end
            cidat_pkg::S_WRITE: begin
                if (last) begin
                    state_next = cidat_pkg::S_RESULT;
                end
            end
            cidat_pkg::S_RESULT: begin
                if (out_free) begin
                    state_next = cidat_pkg::S_IDLE;
                end
            end
            default: state_next = cidat_pkg::S_IDLE;
        endcase
    end

    // Outputs toward the input channel and the ring
    always_comb begin
        s_tready  = (state_reg == cidat_pkg::S_IDLE);
        ctl.shift = (state_reg == cidat_pkg::S_SCAN) || (state_reg == cidat_pkg::S_WRITE);
        ctl.clear = (state_reg == cidat_pkg::S_IDLE) && s_tvalid
                    && (in_op == cidat_pkg::OP_CLEAR);
        wb        = head;
        if ((state_reg == cidat_pkg::S_SCAN) && first_hit) begin
            if (op_reg == cidat_pkg::OP_DELETE) begin
                wb.id    = '0;
                wb.valid = 1'b0;
            end
            if (op_reg == cidat_pkg::OP_SEARCH) begin
                wb.hits = head_hits_inc;
            end
        end
        if ((state_reg == cidat_pkg::S_WRITE) && (pos_reg == slot_reg)) begin
            wb.id    = id_reg;
            wb.valid = 1'b1;
        end
    end

    // Datapath
    always_comb begin
        op_next       = op_reg;
        id_next       = id_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cnt_free_next = cnt_free_reg;
        hits_next     = hits_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            cidat_pkg::S_IDLE: begin
                if (accept) begin
                    op_next       = in_op;
                    id_next       = s_tdata;
                    pos_next      = '0;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    cnt_free_next = 1'b0;
                    case (in_op)
                        cidat_pkg::OP_INSERT: begin
                            res_next = mk_result(1'b0, cidat_pkg::ST_FULL, '0, count_reg, '0);
                        end
                        cidat_pkg::OP_CLEAR: begin
                            count_next = '0;
                            res_next   = mk_result(1'b1, cidat_pkg::ST_OK, '0, '0, '0);
                        end
                        default: begin
                            res_next = mk_result(1'b0, cidat_pkg::ST_EMPTY, '0, count_reg, '0);
                        end
                    endcase
                end
            end
            cidat_pkg::S_SCAN: begin
                pos_next = last ? '0 : pos_reg + IDX_W'(1);
                if (first_hit) begin
                    found_next = 1'b1;
                    slot_next  = pos_reg;
                    hits_next  = head_hits_inc;
                end
                if (!head.valid && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = pos_reg;
                end
                if (pos_is_count && !head.valid) begin
                    cnt_free_next = 1'b1;
                end
                if (last) begin
                    case (op_reg)
                        cidat_pkg::OP_INSERT: begin
                            if (found_reg || match) begin
                                res_next = mk_result(1'b0, cidat_pkg::ST_DUP, '0, count_reg, '0);
                            end else if (!free_now) begin
                                res_next = mk_result(1'b0, cidat_pkg::ST_FULL, '0, count_reg, '0);
                            end else begin
                                slot_next = target;
                            end
                        end
                        cidat_pkg::OP_DELETE: begin
                            if (found_reg || match) begin
                                count_next = count_reg - CNT_W'(1);
                                res_next   = mk_result(1'b1, cidat_pkg::ST_OK, hit_idx,
                                                       count_reg - CNT_W'(1), '0);
                            end else begin
                                res_next = mk_result(1'b0, cidat_pkg::ST_NOTFOUND, '0,
                                                     count_reg, '0);
                            end
                        end
                        default: begin
                            if (found_reg || match) begin
                                res_next = mk_result(1'b1, cidat_pkg::ST_OK, hit_idx, count_reg,
                                                     found_reg ? hits_reg : head_hits_inc);
                            end else begin
                                res_next = mk_result(1'b0, cidat_pkg::ST_NOTFOUND, '0,
                                                     count_reg, '0);
                            end
                        end
                    endcase
                end
            end
            cidat_pkg::S_WRITE: begin
                pos_next = last ? '0 : pos_reg + IDX_W'(1);
                if (last) begin
                    count_next = count_reg + CNT_W'(1);
                    res_next   = mk_result(1'b1, cidat_pkg::ST_OK, slot_reg,
                                           count_reg + CNT_W'(1), '0);
                end
            end
            cidat_pkg::S_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(cidat_pkg::OUT_W - RES_W){1'b0}},
                                    res_reg.hits, res_reg.occupied, res_reg.slot,
                                    res_reg.status, res_reg.success};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cidat_pkg::S_IDLE;
            pos_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        cnt_free_reg <= cnt_free_next;
        hits_reg     <= hits_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_pos_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg != '0) |-> ((state_reg == cidat_pkg::S_SCAN)
                             || (state_reg == cidat_pkg::S_WRITE)))
        else $error("ring left mid-rotation");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_op == cidat_pkg::OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    a_write_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cidat_pkg::S_WRITE) |-> (slot_reg <= IDX_W'(DEPTH - 1)))
        else $error("insert target outside table");
`endif

endmodule

`default_nettype wire

// ===== dv/card_id_allow_table_core_tb.sv =====
`default_nettype none

module card_id_allow_table_core_tb;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic                         success;
        cidat_pkg::status_t           status;
        logic [cidat_pkg::SLOT_W-1:0] slot;
        logic [cidat_pkg::OCC_W-1:0]  occupied;
        logic [cidat_pkg::HITS_W-1:0] hits;
    } reply_t;

    typedef struct packed {
        cidat_pkg::opcode_t op;
        logic [31:0]        id;
        logic               typed;
        reply_t             want;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    card_id_allow_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the table
    logic [31:0] card_ids  [DEPTH];
    logic        slot_used [DEPTH];
    logic [7:0]  slot_hits [DEPTH];
    int unsigned live_count;

    reply_t reply_q[$];
    reply_t got;
    reply_t want;

    int fail_count    = 0;
    int replies_seen  = 0;
    int requests_sent = 0;
    int burst_left    = 0;
    int full_seen     = 0;
    int dup_seen      = 0;
    int miss_seen     = 0;
    int empty_seen    = 0;
    int wrap_seen     = 0;
    int peak_count    = 0;

    // Expected results that can be read straight off the behavior are typed in
    dir_row_t dir_rows [19] = '{
        '{cidat_pkg::OP_SEARCH, 32'h0000_0000, 1'b1,
          '{1'b0, cidat_pkg::ST_EMPTY, 6'd0, 7'd0, 8'd0}},
        '{cidat_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, cidat_pkg::ST_EMPTY, 6'd0, 7'd0, 8'd0}},
        '{cidat_pkg::OP_INSERT, 32'h0000_0000, 1'b1,
          '{1'b1, cidat_pkg::ST_OK, 6'd0, 7'd1, 8'd0}},
        '{cidat_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, cidat_pkg::ST_OK, 6'd1, 7'd2, 8'd0}},
        '{cidat_pkg::OP_INSERT, 32'h0000_0000, 1'b1,
          '{1'b0, cidat_pkg::ST_DUP, 6'd0, 7'd2, 8'd0}},
        '{cidat_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, cidat_pkg::ST_OK, 6'd1, 7'd2, 8'd1}},
        '{cidat_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b0, '0},
        '{cidat_pkg::OP_SEARCH, 32'h1234_5678, 1'b1,
          '{1'b0, cidat_pkg::ST_NOTFOUND, 6'd0, 7'd2, 8'd0}},
        '{cidat_pkg::OP_DELETE, 32'h0000_0000, 1'b1,
          '{1'b1, cidat_pkg::ST_OK, 6'd0, 7'd1, 8'd0}},
        // deleted slot still holds a zero ID but is no longer valid
        '{cidat_pkg::OP_SEARCH, 32'h0000_0000, 1'b1,
          '{1'b0, cidat_pkg::ST_NOTFOUND, 6'd0, 7'd1, 8'd0}},
        // slot at the count index is taken: expect the lowest free slot
        '{cidat_pkg::OP_INSERT, 32'hA5A5_A5A5, 1'b0, '0},
        '{cidat_pkg::OP_DELETE, 32'h5A5A_5A5A, 1'b0, '0},
        '{cidat_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b0, '0},
        '{cidat_pkg::OP_INSERT, 32'h8000_0001, 1'b0, '0},
        '{cidat_pkg::OP_SEARCH, 32'hA5A5_A5A5, 1'b0, '0},
        '{cidat_pkg::OP_CLEAR,  32'h0000_0000, 1'b1,
          '{1'b1, cidat_pkg::ST_OK, 6'd0, 7'd0, 8'd0}},
        '{cidat_pkg::OP_SEARCH, 32'hA5A5_A5A5, 1'b1,
          '{1'b0, cidat_pkg::ST_EMPTY, 6'd0, 7'd0, 8'd0}},
        '{cidat_pkg::OP_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
        '{cidat_pkg::OP_CLEAR,  32'hFFFF_FFFF, 1'b1,
          '{1'b1, cidat_pkg::ST_OK, 6'd0, 7'd0, 8'd0}}
    };

    function automatic int find_card(input logic [31:0] id);
        for (int k = 0; k < DEPTH; k++) begin
            if (slot_used[k] && card_ids[k] == id) return k;
        end
        return -1;
    endfunction

    task automatic wipe_table();
        for (int k = 0; k < DEPTH; k++) begin
            card_ids[k]  = '0;
            slot_used[k] = 1'b0;
            slot_hits[k] = '0;
        end
        live_count = 0;
    endtask

    task automatic predict_table_reply(input cidat_pkg::opcode_t op, input logic [31:0] id,
                                       output reply_t r);
        int match;
        int target;
        r = '0;
        r.status = cidat_pkg::ST_OK;
        match = find_card(id);
        case (op)
            cidat_pkg::OP_INSERT: begin
                if (live_count >= DEPTH) begin
                    r.status = cidat_pkg::ST_FULL;
                end else if (match >= 0) begin
                    r.status = cidat_pkg::ST_DUP;
                end else begin
                    target = -1;
                    if (!slot_used[live_count]) begin
                        target = live_count;
                    end else begin
                        for (int k = 0; k < DEPTH; k++) begin
                            if (!slot_used[k]) begin
                                target = k;
                                break;
                            end
                        end
                    end
                    if (target < 0) begin
                        r.status = cidat_pkg::ST_FULL;
                    end else begin
                        card_ids[target]  = id;
                        slot_used[target] = 1'b1;
                        live_count++;
                        r.success = 1'b1;
                        r.slot    = target[cidat_pkg::SLOT_W-1:0];
                    end
                end
            end
            cidat_pkg::OP_DELETE, cidat_pkg::OP_SEARCH: begin
                if (live_count == 0) begin
                    r.status = cidat_pkg::ST_EMPTY;
                end else if (match < 0) begin
                    r.status = cidat_pkg::ST_NOTFOUND;
                end else begin
                    r.success = 1'b1;
                    r.slot    = match[cidat_pkg::SLOT_W-1:0];
                    if (op == cidat_pkg::OP_DELETE) begin
                        card_ids[match]  = '0;
                        slot_used[match] = 1'b0;
                        live_count--;
                    end else begin
                        slot_hits[match] = slot_hits[match] + 8'd1;
                        r.hits = slot_hits[match];
                    end
                end
            end
            default: begin
                wipe_table();
                r.success = 1'b1;
            end
        endcase
        r.occupied = live_count[cidat_pkg::OCC_W-1:0];
        if (live_count > peak_count) peak_count = live_count;
    endtask

    // Pick a card ID: one in the table with present_pct percent chance, sometimes an extreme, else random
    function automatic logic [31:0] pick_card(input int present_pct);
        int roll;
        int start;
        int idx;
        roll = $urandom_range(0, 99);
        if (roll < 4) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        if (roll < 4 + present_pct && live_count > 0) begin
            start = $urandom_range(0, DEPTH - 1);
            for (int k = 0; k < DEPTH; k++) begin
                idx = (start + k) % DEPTH;
                if (slot_used[idx]) return card_ids[idx];
            end
        end
        return $urandom;
    endfunction

    task automatic send_request(input cidat_pkg::opcode_t op, input logic [31:0] id,
                                input logic typed, input reply_t typed_reply);
        reply_t r;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tuser  <= {6'b0, op};
        do @(posedge aclk); while (!s_tready);
        predict_table_reply(op, id, r);
        reply_q.push_back(typed ? typed_reply : r);
        requests_sent++;
        // burst of back-to-back items, then a random gap
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 12);
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int present_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            send_request(cidat_pkg::OP_INSERT, pick_card(present_pct / 3), 1'b0, '0);
        end else if (roll < 60) begin
            send_request(cidat_pkg::OP_DELETE, pick_card(present_pct), 1'b0, '0);
        end else if (roll < 99) begin
            send_request(cidat_pkg::OP_SEARCH, pick_card(present_pct), 1'b0, '0);
        end else begin
            send_request(cidat_pkg::OP_CLEAR, $urandom, 1'b0, '0);
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge aclk);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen <= replies_seen + 1;
            got.success  = m_tdata[0];
            got.status   = cidat_pkg::status_t'(m_tdata[3:1]);
            got.slot     = m_tdata[9:4];
            got.occupied = m_tdata[16:10];
            got.hits     = m_tdata[24:17];
            if (reply_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected result item: data %h", m_tdata);
            end else begin
                want = reply_q.pop_front();
                case (want.status)
                    cidat_pkg::ST_FULL:     full_seen++;
                    cidat_pkg::ST_DUP:      dup_seen++;
                    cidat_pkg::ST_NOTFOUND: miss_seen++;
                    cidat_pkg::ST_EMPTY:    empty_seen++;
                    default:                ;
                endcase
                if (got.success !== want.success || got.status !== want.status
                    || got.slot !== want.slot || got.occupied !== want.occupied
                    || got.hits !== want.hits) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch at result %0d: success %b/%b status %0d/%0d",
                                 replies_seen, want.success, got.success,
                                 want.status, got.status);
                        $display("    slot %0d/%0d occupied %0d/%0d hits %0d/%0d",
                                 want.slot, got.slot, want.occupied, got.occupied,
                                 want.hits, got.hits);
                    end
                end
            end
        end
    end

    // Receiver: phases of varying stall density, plus one long hold-off
    int  hold_left      = 0;
    int  phase_left     = 0;
    int  stall_pct      = 0;
    bit  long_hold_done = 1'b0;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!long_hold_done && replies_seen >= 350) begin
            long_hold_done = 1'b1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(30, 300);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            phase_left = phase_left - 1;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("timeout waiting for results, %0d still expected", reply_q.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [31:0] hot_id;
        wipe_table();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].op, dir_rows[i].id, dir_rows[i].typed, dir_rows[i].want);
        end

        // fill to capacity, with some duplicates, then push past full, search and swap entries
        send_request(cidat_pkg::OP_CLEAR, $urandom, 1'b0, '0);
        while (live_count < DEPTH) begin
            if ($urandom_range(0, 9) == 0 && live_count > 0)
                send_request(cidat_pkg::OP_INSERT, pick_card(100), 1'b0, '0);
            else
                send_request(cidat_pkg::OP_INSERT, $urandom, 1'b0, '0);
        end
        repeat (3) send_request(cidat_pkg::OP_INSERT, $urandom, 1'b0, '0);
        repeat (3) send_request(cidat_pkg::OP_INSERT, pick_card(100), 1'b0, '0);
        repeat (6) send_request(cidat_pkg::OP_SEARCH, pick_card(100), 1'b0, '0);
        repeat (4) begin
            send_request(cidat_pkg::OP_DELETE, pick_card(100), 1'b0, '0);
            send_request(cidat_pkg::OP_INSERT, $urandom, 1'b0, '0);
        end

        // hold off until the table is quiet, then hammer one ID past hit wrap
        drain_replies();
        send_request(cidat_pkg::OP_CLEAR, $urandom, 1'b0, '0);
        hot_id = $urandom;
        send_request(cidat_pkg::OP_INSERT, $urandom, 1'b0, '0);
        send_request(cidat_pkg::OP_INSERT, hot_id, 1'b0, '0);
        send_request(cidat_pkg::OP_INSERT, $urandom, 1'b0, '0);
        for (int i = 0; i < 300; i++) begin
            if (i % 8 == 7)
                send_request(cidat_pkg::opcode_t'($urandom_range(0, 1) ? cidat_pkg::OP_INSERT
                                                                      : cidat_pkg::OP_SEARCH),
                             $urandom, 1'b0, '0);
            else
                send_request(cidat_pkg::OP_SEARCH, hot_id, 1'b0, '0);
        end
        wrap_seen = slot_hits[find_card(hot_id)] < 8'd250 ? 1 : 0;

        // mixed traffic on random content
        for (int i = 0; i < 700; i++) begin
            send_random(70);
        end

        drain_replies();
        repeat (2 * DEPTH + 20) @(posedge aclk);
        $display("covered %0d requests, peak occupancy %0d, hit counter wrapped: %0d",
                 requests_sent, peak_count, wrap_seen);
        $display("rejects seen: full %0d, duplicate %0d, not found %0d, empty %0d",
                 full_seen, dup_seen, miss_seen, empty_seen);
        if (fail_count == 0 && reply_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures", fail_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
